[sv/hxs_pkg.sv]
// shared types, constants and code tables of the hid usage to xt scancode translator
`timescale 1ns / 1ps

package hxs_pkg;

  // input item operations
  localparam logic [1:0] OP_KEY_DOWN = 2'd0;
  localparam logic [1:0] OP_KEY_UP   = 2'd1;
  localparam logic [1:0] OP_PAD      = 2'd2;

  localparam int unsigned PAD_BUTTONS  = 6;
  localparam logic [5:0]  PAD_ALL_UP   = 6'h3F;
  localparam logic [7:0]  EXT_PREFIX   = 8'hE0;
  localparam logic [7:0]  BREAK_BIT    = 8'h80;
  localparam int unsigned QUEUE_DEPTH  = 4;

  // one input word
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] hid_usage;
    logic [5:0] pad_mask;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic [7:0] scan_byte;
    logic       last_byte;
  } out_word_t;

  // make code with its extended flag; make of zero means unmapped
  typedef struct packed {
    logic       ext;
    logic [7:0] make;
  } key_code_t;

  // work entry between front and back
  typedef struct packed {
    logic       is_pad;
    key_code_t  code;
    logic       is_break;
    logic [5:0] changed;
    logic [5:0] rel_mask;
  } entry_t;

  typedef logic [7:0] letter_tbl_t [0:25];

  localparam letter_tbl_t LETTER_CODES = '{
    8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
    8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14, 8'h16, 8'h2F, 8'h11, 8'h2D,
    8'h15, 8'h2C
  };

  // hid usage to set-1 make code
  function automatic key_code_t lookup_make(input logic [7:0] u);
    key_code_t  r;
    logic [4:0] li;
    r  = '0;
    li = 5'(u - 8'h04);
    if (u inside {[8'h04:8'h1D]}) begin
      r.make = LETTER_CODES[li];
    end else if (u inside {[8'h1E:8'h26]}) begin
      r.make = 8'h02 + (u - 8'h1E);
    end else if (u inside {[8'h3A:8'h43]}) begin
      r.make = 8'h3B + (u - 8'h3A);
    end else begin
      case (u)
        8'h27: r.make = 8'h0B;
        8'h28: r.make = 8'h1C;
        8'h29: r.make = 8'h01;
        8'h2A: r.make = 8'h0E;
        8'h2B: r.make = 8'h0F;
        8'h2C: r.make = 8'h39;
        8'h2D: r.make = 8'h0C;
        8'h2E: r.make = 8'h0D;
        8'h2F: r.make = 8'h1A;
        8'h30: r.make = 8'h1B;
        8'h31: r.make = 8'h2B;
        8'h33: r.make = 8'h27;
        8'h34: r.make = 8'h28;
        8'h35: r.make = 8'h29;
        8'h36: r.make = 8'h33;
        8'h37: r.make = 8'h34;
        8'h38: r.make = 8'h35;
        8'h39: r.make = 8'h3A;
        8'h44: r.make = 8'h57;
        8'h45: r.make = 8'h58;
        8'h4F: r = '{ext: 1'b1, make: 8'h4D};
        8'h50: r = '{ext: 1'b1, make: 8'h4B};
        8'h51: r = '{ext: 1'b1, make: 8'h50};
        8'h52: r = '{ext: 1'b1, make: 8'h48};
        8'hE0: r.make = 8'h1D;
        8'hE1: r.make = 8'h2A;
        8'hE2: r.make = 8'h38;
        8'hE4: r = '{ext: 1'b1, make: 8'h1D};
        8'hE5: r.make = 8'h36;
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  // gamepad button to its key: up, down, left, right, enter, escape
  function automatic key_code_t pad_code(input logic [2:0] idx);
    key_code_t r;
    r = '0;
    case (idx)
      3'd0: r = '{ext: 1'b1, make: 8'h48};
      3'd1: r = '{ext: 1'b1, make: 8'h50};
      3'd2: r = '{ext: 1'b1, make: 8'h4B};
      3'd3: r = '{ext: 1'b1, make: 8'h4D};
      3'd4: r = '{ext: 1'b0, make: 8'h1C};
      3'd5: r = '{ext: 1'b0, make: 8'h01};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[sv/hid_usage_to_xt_scancode.sv]
// top level: hid keyboard usages and gamepad masks to xt set-1 scancode bytes
// path: a word goes from the work queue to the current entry and then to out_word
// throughput: a word is taken every cycle while the work queue has room; the back
//   sequencer emits one byte per cycle while out_word is empty or popped (1-2 per key,
//   up to 10 per gamepad word), and none while it loads a queued entry
// reset: synchronous on rst_n low; queue and output emptied, gamepad mask set to all up
`timescale 1ns / 1ps

module hid_usage_to_xt_scancode #(
  parameter int unsigned QUEUE_DEPTH = hxs_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hxs_pkg::in_word_t  in_word,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output hxs_pkg::out_word_t out_word
);

  logic            q_push, q_full, q_pop, q_empty;
  hxs_pkg::entry_t q_wdata, q_rdata;

  // classify incoming words
  hxs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_word (in_word),
    .full    (full),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  // work queue
  hxs_fifo #(
    .WIDTH ($bits(hxs_pkg::entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // emit scancode bytes
  hxs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

  // front never writes a full queue
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("queue written while full");

  // back never reads an empty queue
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("queue read while empty");

  // reset leaves the output empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty) else $error("output not empty after reset");

endmodule

[sv/hxs_fifo.sv]
// small flop-based queue between the front and back parts
`timescale 1ns / 1ps

module hxs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = hxs_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[sv/hxs_front.sv]
// front part: accepts words, looks up keys, diffs the gamepad mask
`timescale 1ns / 1ps

module hxs_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hxs_pkg::in_word_t in_word,
  output logic             full,
  output logic             q_push,
  output hxs_pkg::entry_t  q_data,
  input  logic             q_full
);

  logic [5:0]         prev_mask_r, prev_mask_nxt;
  logic               accept;
  logic               is_key, is_pad;
  hxs_pkg::key_code_t kc;
  logic [5:0]         changed;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign is_key = (in_word.opcode == hxs_pkg::OP_KEY_DOWN) ||
                  (in_word.opcode == hxs_pkg::OP_KEY_UP);
  assign is_pad = (in_word.opcode == hxs_pkg::OP_PAD);
  assign kc      = hxs_pkg::lookup_make(in_word.hid_usage);
  assign changed = prev_mask_r ^ in_word.pad_mask;

  // build the work entry
  always_comb begin
    q_data          = '0;
    q_data.is_pad   = is_pad;
    q_data.code     = kc;
    q_data.is_break = (in_word.opcode == hxs_pkg::OP_KEY_UP);
    q_data.changed  = changed;
    q_data.rel_mask = in_word.pad_mask;
    q_push = accept && ((is_key && (kc.make != 8'h00)) || (is_pad && (changed != '0)));
  end

  // stored gamepad mask
  always_comb begin
    prev_mask_nxt = prev_mask_r;
    if (accept && is_pad) begin
      prev_mask_nxt = in_word.pad_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_mask_r <= hxs_pkg::PAD_ALL_UP;
    end else begin
      prev_mask_r <= prev_mask_nxt;
    end
  end

endmodule

[sv/hxs_back.sv]
// back part: walks one entry and emits its scancode bytes into the output register
`timescale 1ns / 1ps

module hxs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  hxs_pkg::entry_t   q_data,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output hxs_pkg::out_word_t out_word
);

  hxs_pkg::entry_t    cur_r, cur_nxt;
  logic               cur_valid_r, cur_valid_nxt;
  logic [5:0]         rem_r, rem_nxt;
  logic               pfx_r, pfx_nxt;
  logic               out_valid_r, out_valid_nxt;
  hxs_pkg::out_word_t out_r, out_nxt;

  logic [2:0]         idx;
  hxs_pkg::key_code_t ev;
  logic               rel;
  logic               pfx_step;
  logic [5:0]         rem_after;
  logic               fin;
  logic               step;
  logic [7:0]         code_byte;

  // lowest pending button
  always_comb begin
    idx = '0;
    for (int i = hxs_pkg::PAD_BUTTONS - 1; i >= 0; i--) begin
      if (rem_r[i]) begin
        idx = 3'(i);
      end
    end
  end

  // current key event
  always_comb begin
    if (cur_r.is_pad) begin
      ev  = hxs_pkg::pad_code(idx);
      rel = cur_r.rel_mask[idx];
    end else begin
      ev  = cur_r.code;
      rel = cur_r.is_break;
    end
    pfx_step  = ev.ext && !pfx_r;
    rem_after = rem_r & (rem_r - 6'd1);
    fin       = !pfx_step && (!cur_r.is_pad || (rem_after == '0));
    code_byte = rel ? (ev.make | hxs_pkg::BREAK_BIT) : ev.make;
    step      = cur_valid_r && (!out_valid_r || pop);
    q_pop     = !cur_valid_r && !q_empty;
  end

  // sequencer next values
  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    rem_nxt       = rem_r;
    pfx_nxt       = pfx_r;
    if (q_pop) begin
      cur_nxt       = q_data;
      cur_valid_nxt = 1'b1;
      rem_nxt       = q_data.changed;
      pfx_nxt       = 1'b0;
    end else if (step) begin
      pfx_nxt = pfx_step;
      if (!pfx_step) begin
        rem_nxt = rem_after;
      end
      if (fin) begin
        cur_valid_nxt = 1'b0;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (step) begin
      out_valid_nxt     = 1'b1;
      out_nxt.scan_byte = pfx_step ? hxs_pkg::EXT_PREFIX : code_byte;
      out_nxt.last_byte = fin;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign empty    = !out_valid_r;
  assign out_word = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      pfx_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      pfx_r       <= pfx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    rem_r <= rem_nxt;
    out_r <= out_nxt;
  end

endmodule

[sim/tb_hid_usage_to_xt_scancode.sv]
// testbench for the hid usage to xt set-1 scancode translator, checked by its own predictor
`timescale 1ns / 1ps

module tb_hid_usage_to_xt_scancode;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int unsigned RAND_WORDS = 350;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 12;

  // hid usages of the gamepad buttons in mask bit order, then right ctrl
  localparam logic [7:0] USAGE_UP    = 8'h52;
  localparam logic [7:0] USAGE_DOWN  = 8'h51;
  localparam logic [7:0] USAGE_LEFT  = 8'h50;
  localparam logic [7:0] USAGE_RIGHT = 8'h4F;
  localparam logic [7:0] USAGE_ENTER = 8'h28;
  localparam logic [7:0] USAGE_ESC   = 8'h29;
  localparam logic [7:0] USAGE_RCTRL = 8'hE4;

  logic               clk;
  logic               rst_n;
  logic               push;
  hxs_pkg::in_word_t  in_word;
  logic               full;
  logic               empty;
  logic               pop;
  hxs_pkg::out_word_t out_word;

  // predictor state and expected scancode words
  logic [5:0]         pad_state;
  hxs_pkg::out_word_t expected_bytes [$];

  bit idle_on;
  int unsigned pop_hold;
  int unsigned cycles;
  int unsigned mismatches;
  int unsigned key_words, pad_words, unused_words, bytes_checked;

  hid_usage_to_xt_scancode DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_word  (in_word),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // gap length: mostly short, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // set-1 make code of a hid usage, {ext, make}; make of zero means no key
  function automatic logic [8:0] xt_make_code(input logic [7:0] usage);
    logic [7:0] m;
    logic       ext;
    m   = 8'h00;
    ext = 1'b0;
    if (usage >= 8'h1E && usage <= 8'h26) begin
      m = 8'h02 + (usage - 8'h1E);
    end else if (usage >= 8'h3A && usage <= 8'h43) begin
      m = 8'h3B + (usage - 8'h3A);
    end else begin
      case (usage)
        8'h04: m = 8'h1E; 8'h05: m = 8'h30; 8'h06: m = 8'h2E; 8'h07: m = 8'h20;
        8'h08: m = 8'h12; 8'h09: m = 8'h21; 8'h0A: m = 8'h22; 8'h0B: m = 8'h23;
        8'h0C: m = 8'h17; 8'h0D: m = 8'h24; 8'h0E: m = 8'h25; 8'h0F: m = 8'h26;
        8'h10: m = 8'h32; 8'h11: m = 8'h31; 8'h12: m = 8'h18; 8'h13: m = 8'h19;
        8'h14: m = 8'h10; 8'h15: m = 8'h13; 8'h16: m = 8'h1F; 8'h17: m = 8'h14;
        8'h18: m = 8'h16; 8'h19: m = 8'h2F; 8'h1A: m = 8'h11; 8'h1B: m = 8'h2D;
        8'h1C: m = 8'h15; 8'h1D: m = 8'h2C;
        8'h27: m = 8'h0B; 8'h28: m = 8'h1C; 8'h29: m = 8'h01; 8'h2A: m = 8'h0E;
        8'h2B: m = 8'h0F; 8'h2C: m = 8'h39; 8'h2D: m = 8'h0C; 8'h2E: m = 8'h0D;
        8'h2F: m = 8'h1A; 8'h30: m = 8'h1B; 8'h31: m = 8'h2B; 8'h33: m = 8'h27;
        8'h34: m = 8'h28; 8'h35: m = 8'h29; 8'h36: m = 8'h33; 8'h37: m = 8'h34;
        8'h38: m = 8'h35; 8'h39: m = 8'h3A; 8'h44: m = 8'h57; 8'h45: m = 8'h58;
        8'h4F: begin m = 8'h4D; ext = 1'b1; end
        8'h50: begin m = 8'h4B; ext = 1'b1; end
        8'h51: begin m = 8'h50; ext = 1'b1; end
        8'h52: begin m = 8'h48; ext = 1'b1; end
        8'hE0: m = 8'h1D; 8'hE1: m = 8'h2A; 8'hE2: m = 8'h38; 8'hE5: m = 8'h36;
        8'hE4: begin m = 8'h1D; ext = 1'b1; end
        default: m = 8'h00;
      endcase
    end
    return {ext, m};
  endfunction

  // bytes of one key event appended to a word list
  function automatic void key_bytes(input logic [7:0] usage, input bit is_break,
                                    inout hxs_pkg::out_word_t seq [$]);
    logic [8:0]         code;
    hxs_pkg::out_word_t w;
    code = xt_make_code(usage);
    if (code[7:0] == 8'h00) return;
    if (code[8]) begin
      w.scan_byte = hxs_pkg::EXT_PREFIX;
      w.last_byte = 1'b0;
      seq = {seq, w};
    end
    w.scan_byte = is_break ? (code[7:0] | hxs_pkg::BREAK_BIT) : code[7:0];
    w.last_byte = 1'b0;
    seq = {seq, w};
  endfunction

  // expected scancode words of one accepted input word
  function automatic void predict_scancodes(input hxs_pkg::in_word_t w);
    hxs_pkg::out_word_t seq [$];
    logic [7:0]         pad_keys [hxs_pkg::PAD_BUTTONS];
    bit                 now_down, was_down;
    pad_keys = '{USAGE_UP, USAGE_DOWN, USAGE_LEFT, USAGE_RIGHT, USAGE_ENTER, USAGE_ESC};
    case (w.opcode)
      hxs_pkg::OP_KEY_DOWN, hxs_pkg::OP_KEY_UP: begin
        key_bytes(w.hid_usage, w.opcode == hxs_pkg::OP_KEY_UP, seq);
        key_words++;
      end
      hxs_pkg::OP_PAD: begin
        for (int i = 0; i < hxs_pkg::PAD_BUTTONS; i++) begin
          now_down = !w.pad_mask[i];
          was_down = !pad_state[i];
          if (now_down != was_down) key_bytes(pad_keys[i], !now_down, seq);
        end
        pad_state = w.pad_mask;
        pad_words++;
      end
      default: unused_words++;
    endcase
    if (seq.size() > 0) seq[$].last_byte = 1'b1;
    expected_bytes = {expected_bytes, seq};
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got 0x%02h, expected 0x%02h", $realtime, what, got, want);
    mismatches++;
  endtask

  // send one input word, starting and ending at a falling edge
  task automatic send_word(input logic [1:0] op, input logic [7:0] usage,
                           input logic [5:0] mask);
    int unsigned       gap;
    hxs_pkg::in_word_t w;
    w.opcode    = op;
    w.hid_usage = usage;
    w.pad_mask  = mask;
    gap = idle_on ? gap_len() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (full);
    predict_scancodes(w);
    @(negedge clk);
  endtask

  // result side: random pop stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) pop_hold = gap_len();
    end
  end

  // check each accepted scancode word against the oldest expectation
  always @(posedge clk) begin
    hxs_pkg::out_word_t want;
    if (rst_n && pop && !empty) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected word", out_word.scan_byte, 0);
      end else begin
        want = expected_bytes.pop_front();
        if (out_word.scan_byte !== want.scan_byte)
          report_mismatch("scan_byte", out_word.scan_byte, want.scan_byte);
        if (out_word.last_byte !== want.last_byte)
          report_mismatch("last_byte", out_word.last_byte, want.last_byte);
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // key extremes: unmapped usages, ends of the letter range, F12, pad_mask ignored
  task automatic test_key_extremes();
    send_word(hxs_pkg::OP_KEY_DOWN, 8'h00, 6'h00);
    send_word(hxs_pkg::OP_KEY_UP,   8'hFF, 6'h3F);
    send_word(hxs_pkg::OP_KEY_DOWN, 8'h04, 6'h3F);
    send_word(hxs_pkg::OP_KEY_UP,   8'h1D, 6'h00);
    send_word(hxs_pkg::OP_KEY_DOWN, 8'h45, 6'h15);
    send_word(hxs_pkg::OP_KEY_UP,   8'h45, 6'h2A);
  endtask

  // extended keys get the prefix on make and break
  task automatic test_extended_keys();
    send_word(hxs_pkg::OP_KEY_DOWN, USAGE_UP,    6'h00);
    send_word(hxs_pkg::OP_KEY_UP,   USAGE_RIGHT, 6'h3F);
    send_word(hxs_pkg::OP_KEY_DOWN, USAGE_RCTRL, 6'h3F);
    send_word(hxs_pkg::OP_KEY_UP,   USAGE_RCTRL, 6'h00);
  endtask

  // gamepad: all pressed, unchanged, all released, alternating bits, keys in between
  task automatic test_pad_updates();
    send_word(hxs_pkg::OP_PAD, 8'hFF, 6'h00);
    send_word(hxs_pkg::OP_PAD, 8'h00, 6'h00);
    send_word(hxs_pkg::OP_KEY_DOWN, 8'h2C, 6'h3F);
    send_word(hxs_pkg::OP_PAD, 8'hA5, 6'h3F);
    send_word(hxs_pkg::OP_PAD, 8'h5A, 6'h2A);
    send_word(hxs_pkg::OP_PAD, 8'h00, 6'h15);
    send_word(hxs_pkg::OP_PAD, 8'h00, 6'h3F);
  endtask

  // unused opcode leaves the stored mask alone
  task automatic test_unused_opcode();
    send_word(OP_UNUSED,        USAGE_UP, 6'h00);
    send_word(hxs_pkg::OP_PAD,  8'h00,    6'h3F);
    send_word(OP_UNUSED,        8'hFF,    6'h3F);
  endtask

  // random traffic: mostly mapped keys and one-button pad changes
  task automatic test_random_traffic();
    int unsigned n, r;
    logic [1:0]  op;
    logic [7:0]  usage;
    logic [5:0]  mask;
    n = 0;
    while (n < RAND_WORDS) begin
      if (n % 25 == 0) idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      op = (r < 40) ? hxs_pkg::OP_KEY_DOWN : (r < 75) ? hxs_pkg::OP_KEY_UP :
           (r < 95) ? hxs_pkg::OP_PAD : OP_UNUSED;
      r = $urandom_range(0, 99);
      usage = (r < 55) ? 8'($urandom_range(8'h04, 8'h52)) :
              (r < 75) ? 8'($urandom_range(8'hE0, 8'hE7)) : 8'($urandom_range(0, 255));
      mask = ($urandom_range(0, 1) == 0) ? (pad_state ^ (6'h01 << $urandom_range(0, 5)))
                                         : 6'($urandom_range(0, 63));
      send_word(op, usage, mask);
      n++;
    end
  endtask

  // main sequence
  initial begin
    rst_n    = 1'b0;
    push     = 1'b0;
    in_word  = '0;
    idle_on  = 1'b1;
    mismatches = 0;
    key_words = 0;
    pad_words = 0;
    unused_words = 0;
    pad_state = hxs_pkg::PAD_ALL_UP;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_key_extremes();
    test_extended_keys();
    test_pad_updates();
    test_unused_opcode();
    test_random_traffic();

    push    <= 1'b0;
    idle_on = 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_bytes.size() != 0)
      report_mismatch("words left unreceived", expected_bytes.size(), 0);

    $display("sent %0d key words, %0d gamepad words, %0d unused-opcode words",
             key_words, pad_words, unused_words);
    $display("checked %0d scancode words under random push and pop stalls", bytes_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
